// File: hw/rtl/assert_macros.svh
// assertion macros used by the checker file met_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, held off while reset is asserted
`define MET_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("met assertion failed");

// checked property that also covers the reset cycles
`define MET_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("met reset assertion failed");

`endif

// File: hw/rtl/met_pkg.sv
// shared types, constants and helpers of the escape-time pixel block
`default_nettype none

package met_pkg;

    localparam int FRAC_BITS  = 28;
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int COORD_W = 12;
    localparam int VAL_W   = 32;
    localparam int CNT_W   = 20;
    localparam int COLOR_W = 28;
    localparam int COLOR_SHIFT = 20;
    localparam int CFG_IDX_W = 3;

    // job queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // |z|^2 >= 4 in the double-width product scale
    localparam logic [64:0] ESC_LIMIT = 65'd1 << (2 * FRAC_BITS + 2);

    // register indexes of the config port
    localparam logic [CFG_IDX_W-1:0] CFG_REAL_ORIGIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAG_ORIGIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REAL_STEP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAG_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT  = 3'd4;

    localparam logic signed [VAL_W-1:0] RST_REAL_ORIGIN = -32'sd536870912;
    localparam logic signed [VAL_W-1:0] RST_IMAG_ORIGIN = -32'sd536870912;
    localparam logic signed [VAL_W-1:0] RST_REAL_STEP   = 32'sd1048576;
    localparam logic signed [VAL_W-1:0] RST_IMAG_STEP   = 32'sd1048576;
    localparam logic [CNT_W-1:0]        RST_ITER_LIMIT  = 20'd100000;

    typedef struct packed {
        logic signed [VAL_W-1:0] real_origin;
        logic signed [VAL_W-1:0] imag_origin;
        logic signed [VAL_W-1:0] real_step;
        logic signed [VAL_W-1:0] imag_step;
        logic [CNT_W-1:0]        iter_limit;
    } t_cfg;

    typedef struct packed {
        logic [COORD_W-1:0]      row;
        logic [COORD_W-1:0]      col;
        logic signed [VAL_W-1:0] c_re;
        logic signed [VAL_W-1:0] c_im;
    } t_job;

    // clamp to the 32-bit signed range
    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [47:0] v);
        logic signed [VAL_W-1:0] r;
        if (v[47:31] == {17{1'b0}} || v[47:31] == {17{1'b1}}) begin
            r = v[VAL_W-1:0];
        end else if (v[47]) begin
            r = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(VAL_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/met_fifo.sv
// short job queue between the coordinate front and the iteration engine
`default_nettype none

module met_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  met_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output met_pkg::t_job o_data,
    output logic          o_empty
);
    import met_pkg::*;

    t_job               r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/met_front.sv
// front end: takes pixel words and maps them to the complex point c
`default_nettype none

module met_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  met_pkg::t_cfg                 i_cfg,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [met_pkg::COORD_W-1:0]   i_row,
    input  logic [met_pkg::COORD_W-1:0]   i_col,
    output logic                          o_push,
    output met_pkg::t_job                 o_job,
    input  logic                          i_full
);
    import met_pkg::*;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_MUL  = 3'b010,
        F_SUM  = 3'b100
    } t_fstate;

    t_fstate r_state;
    t_fstate n_state;

    logic [COORD_W-1:0]  r_row;
    logic [COORD_W-1:0]  r_col;
    logic signed [44:0]  r_prod_re;
    logic signed [44:0]  r_prod_im;
    logic [COORD_W-1:0]  idx_re;
    logic [COORD_W-1:0]  idx_im;
    logic signed [44:0]  n_prod_re;
    logic signed [44:0]  n_prod_im;
    logic signed [47:0]  sum_re;
    logic signed [47:0]  sum_im;
    logic                accept;

    assign o_stall = !(r_state == F_IDLE || (r_state == F_SUM && !i_full));
    assign accept  = i_valid && !o_stall;

    // indexes past the image edge would use the last row or column; 12-bit indexes never get there
    assign idx_re = (17'(r_col) >= 17'(MAX_WIDTH))  ? COORD_W'(MAX_WIDTH - 1)  : r_col;
    assign idx_im = (17'(r_row) >= 17'(MAX_HEIGHT)) ? COORD_W'(MAX_HEIGHT - 1) : r_row;

    assign n_prod_re = $signed({1'b0, idx_re}) * i_cfg.real_step;
    assign n_prod_im = $signed({1'b0, idx_im}) * i_cfg.imag_step;

    assign sum_re = 48'(i_cfg.real_origin) + 48'(r_prod_re);
    assign sum_im = 48'(i_cfg.imag_origin) + 48'(r_prod_im);

    assign o_push     = (r_state == F_SUM) && !i_full;
    assign o_job.row  = r_row;
    assign o_job.col  = r_col;
    assign o_job.c_re = sat32(sum_re);
    assign o_job.c_im = sat32(sum_im);

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    n_state = F_MUL;
                end
            end
            F_MUL: begin
                n_state = F_SUM;
            end
            F_SUM: begin
                if (!i_full) begin
                    n_state = i_valid ? F_MUL : F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_row <= i_row;
            r_col <= i_col;
        end
        if (r_state == F_MUL) begin
            r_prod_re <= n_prod_re;
            r_prod_im <= n_prod_im;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/met_back.sv
// back end: z = z*z + c iteration engine with a result register
`default_nettype none

module met_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [met_pkg::CNT_W-1:0]    i_limit,
    input  logic                         i_empty,
    input  met_pkg::t_job                i_job,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [met_pkg::COORD_W-1:0]  o_row,
    output logic [met_pkg::COORD_W-1:0]  o_col,
    output logic [met_pkg::CNT_W-1:0]    o_count,
    output logic [met_pkg::COLOR_W-1:0]  o_colour
);
    import met_pkg::*;

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_MUL  = 3'b010,
        B_UPD  = 3'b100
    } t_bstate;

    t_bstate r_state;
    t_bstate n_state;

    t_job                    r_job;
    logic signed [VAL_W-1:0] r_zr;
    logic signed [VAL_W-1:0] r_zi;
    logic [CNT_W-1:0]        r_count;
    logic signed [63:0]      r_p_rr;
    logic signed [63:0]      r_p_ii;
    logic signed [63:0]      r_p_ri;

    logic signed [63:0]      n_p_rr;
    logic signed [63:0]      n_p_ii;
    logic signed [63:0]      n_p_ri;
    logic signed [63:0]      diff;
    logic signed [63:0]      diff_sh;
    logic signed [63:0]      cross_sh;
    logic signed [47:0]      sum_re;
    logic signed [47:0]      sum_im;
    logic [64:0]             mag2;
    logic                    escaped;
    logic                    done;
    logic                    out_free;
    logic                    finish;

    logic                    r_out_valid;
    logic [COORD_W-1:0]      r_out_row;
    logic [COORD_W-1:0]      r_out_col;
    logic [CNT_W-1:0]        r_out_count;

    assign n_p_rr = r_zr * r_zr;
    assign n_p_ii = r_zi * r_zi;
    assign n_p_ri = r_zr * r_zi;

    // products of the current z also give |z|^2 for the escape test
    assign mag2     = 65'(unsigned'(r_p_rr)) + 65'(unsigned'(r_p_ii));
    assign escaped  = (mag2 >= ESC_LIMIT);
    assign done     = (r_count >= i_limit) || escaped;
    assign out_free = !r_out_valid || !i_stall;
    assign finish   = (r_state == B_UPD) && done && out_free;

    // floor shifts; the doubled cross term uses one bit less of shift
    assign diff     = r_p_rr - r_p_ii;
    assign diff_sh  = diff >>> FRAC_BITS;
    assign cross_sh = r_p_ri >>> (FRAC_BITS - 1);
    assign sum_re   = diff_sh[47:0] + 48'(r_job.c_re);
    assign sum_im   = cross_sh[47:0] + 48'(r_job.c_im);

    assign o_pop = (r_state == B_IDLE) && !i_empty;

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    n_state = B_MUL;
                end
            end
            B_MUL: begin
                n_state = B_UPD;
            end
            B_UPD: begin
                if (!done) begin
                    n_state = B_MUL;
                end else if (out_free) begin
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job   <= i_job;
            r_zr    <= '0;
            r_zi    <= '0;
            r_count <= '0;
        end else if (r_state == B_UPD && !done) begin
            r_zr    <= sat32(sum_re);
            r_zi    <= sat32(sum_im);
            r_count <= r_count + 1'b1;
        end
        if (r_state == B_MUL) begin
            r_p_rr <= n_p_rr;
            r_p_ii <= n_p_ii;
            r_p_ri <= n_p_ri;
        end
        if (finish) begin
            r_out_row   <= r_job.row;
            r_out_col   <= r_job.col;
            r_out_count <= r_count;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_row    = r_out_row;
    assign o_col    = r_out_col;
    assign o_count  = r_out_count;
    assign o_colour = {r_out_count[7:0], COLOR_SHIFT'(0)};

endmodule

`default_nettype wire

// File: hw/rtl/mandelbrot_escape_time_pixel.sv
// the engine works on one pixel at a time and pops the next job only when idle,
// running a multiply/update loop for each pixel
// (three 32x32 multipliers; z is multiplied in B_MUL and updated in B_UPD per iteration)
// the front computes c in F_MUL and F_SUM and queues up to two jobs ahead of the engine
// reset: synchronous active low, config returns to its reset values, queue and
// engine empty; no clearing pass, the first pixel is taken the cycle after reset
`default_nettype none

module mandelbrot_escape_time_pixel (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [met_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [met_pkg::VAL_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [met_pkg::COORD_W-1:0]   i_pixel_row,
    input  logic [met_pkg::COORD_W-1:0]   i_pixel_col,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [met_pkg::COORD_W-1:0]   o_out_row,
    output logic [met_pkg::COORD_W-1:0]   o_out_col,
    output logic [met_pkg::CNT_W-1:0]     o_iteration_count,
    output logic [met_pkg::COLOR_W-1:0]   o_colour_word
);
    import met_pkg::*;

    t_cfg  r_cfg;
    t_job  front_job;
    t_job  queue_job;
    logic  front_push;
    logic  queue_full;
    logic  queue_empty;
    logic  back_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.real_origin <= RST_REAL_ORIGIN;
            r_cfg.imag_origin <= RST_IMAG_ORIGIN;
            r_cfg.real_step   <= RST_REAL_STEP;
            r_cfg.imag_step   <= RST_IMAG_STEP;
            r_cfg.iter_limit  <= RST_ITER_LIMIT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_REAL_ORIGIN: r_cfg.real_origin <= i_cfg_data;
                CFG_IMAG_ORIGIN: r_cfg.imag_origin <= i_cfg_data;
                CFG_REAL_STEP:   r_cfg.real_step   <= i_cfg_data;
                CFG_IMAG_STEP:   r_cfg.imag_step   <= i_cfg_data;
                CFG_ITER_LIMIT:  r_cfg.iter_limit  <= i_cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    met_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_row   (i_pixel_row),
        .i_col   (i_pixel_col),
        .o_push  (front_push),
        .o_job   (front_job),
        .i_full  (queue_full)
    );

    met_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_job),
        .o_full  (queue_full),
        .i_pop   (back_pop),
        .o_data  (queue_job),
        .o_empty (queue_empty)
    );

    met_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_limit  (r_cfg.iter_limit),
        .i_empty  (queue_empty),
        .i_job    (queue_job),
        .o_pop    (back_pop),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_row    (o_out_row),
        .o_col    (o_out_col),
        .o_count  (o_iteration_count),
        .o_colour (o_colour_word)
    );

endmodule

`default_nettype wire

// File: hw/rtl/met_checker.sv
// port-level checks of the escape-time pixel block, bound to the top level
`default_nettype none

`include "assert_macros.svh"

module met_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_in_stall,
    input  logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  logic [met_pkg::COORD_W-1:0]   o_out_row,
    input  logic [met_pkg::COORD_W-1:0]   o_out_col,
    input  logic [met_pkg::CNT_W-1:0]     o_iteration_count,
    input  logic [met_pkg::COLOR_W-1:0]   o_colour_word
);
    import met_pkg::*;

    logic                                  out_held;
    logic [2*COORD_W+CNT_W-1:0]            out_word;
    logic                                  colour_ok;

    assign out_held  = o_out_valid && i_out_stall;
    assign out_word  = {o_out_row, o_out_col, o_iteration_count};
    assign colour_ok = (o_colour_word[COLOR_SHIFT-1:0] == '0)
                    && (o_colour_word[COLOR_W-1:COLOR_SHIFT] == o_iteration_count[7:0]);

    // a result word held back stays offered
    `MET_ASSERT(a_out_hold, i_clk, i_rst_n, out_held |=> o_out_valid)

    // and its payload does not move
    `MET_ASSERT(a_out_stable, i_clk, i_rst_n, out_held |=> $stable(out_word))

    // colour is the low count byte placed above twenty zero bits
    `MET_ASSERT(a_colour, i_clk, i_rst_n, o_out_valid |-> colour_ok)

    // reset empties the engine and frees the front
    `MET_ASSERT_RST(a_reset, i_clk, !i_rst_n |=> !o_out_valid && !o_in_stall)

endmodule

bind mandelbrot_escape_time_pixel met_checker u_met_checker (.*);

`default_nettype wire
